// ----- sv/mqsb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared types and codes for the multi-queue shared buffer: command and
// status codes, the sequencer state type and the slot store control group.
// ----------------------------------------------------------------------------
package mqsb_pkg;

    // Fixed payload widths of the channels.
    localparam int WORD_WIDTH = 32;
    localparam int QID_WIDTH  = 3;

    // Command codes.
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Status codes.
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Sequencer states: wait for a request, then apply it.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } mqsb_state_t;

    // Enables from the sequencer to the slot store.
    typedef struct packed {
        logic rd_en;
        logic link_we;
        logic data_we;
    } mqsb_mem_ctl_t;

endpackage
`default_nettype wire

// ----- sv/mqsb_slot_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mqsb_slot_store
// Slot word and link memories with registered synchronous reads. A high-water
// mark stands in for the reset chain of the link memory: a slot that was
// never handed out reads its link as the next slot, the last one as null.
// ----------------------------------------------------------------------------
module mqsb_slot_store #(
    parameter int SLOTS      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire mqsb_pkg::mqsb_mem_ctl_t  ctl,
    input  wire [$clog2(SLOTS)-1:0]       rd_addr,
    input  wire [$clog2(SLOTS)-1:0]       link_wr_addr,
    input  wire [$clog2(SLOTS+1)-1:0]     link_wr_data,
    input  wire [$clog2(SLOTS)-1:0]       data_wr_addr,
    input  wire [DATA_WIDTH-1:0]          data_wr_data,
    output logic [$clog2(SLOTS+1)-1:0]    link_rd,
    output logic [DATA_WIDTH-1:0]         data_rd
);

    localparam int AW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS + 1);
    localparam logic [PW-1:0] LINK_NULL = PW'(SLOTS);

    logic [PW-1:0]         link_mem [SLOTS];
    logic [DATA_WIDTH-1:0] data_mem [SLOTS];

    logic [PW-1:0]         mark_reg;
    logic [PW-1:0]         link_q_reg;
    logic [DATA_WIDTH-1:0] data_q_reg;
    logic [AW-1:0]         addr_q_reg;
    logic                  fresh_q_reg;

    // Link memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.link_we)
        begin
            link_mem[link_wr_addr] <= link_wr_data;
        end
        if (ctl.rd_en)
        begin
            link_q_reg <= link_mem[rd_addr];
        end
    end

    // Word memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.data_we)
        begin
            data_mem[data_wr_addr] <= data_wr_data;
        end
        if (ctl.rd_en)
        begin
            data_q_reg <= data_mem[rd_addr];
        end
    end

    // Read address and whether it lies at or above the high-water mark.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            addr_q_reg  <= rd_addr;
            fresh_q_reg <= (PW'(rd_addr) >= mark_reg);
        end
    end

    // Slots are handed out from the untouched region in ascending order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= '0;
        end
        else if (ctl.data_we && (PW'(data_wr_addr) == mark_reg))
        begin
            mark_reg <= mark_reg + PW'(1);
        end
    end

    // An untouched slot links to its successor; the last slot ends the chain.
    always_comb
    begin
        if (!fresh_q_reg)
        begin
            link_rd = link_q_reg;
        end
        else if (addr_q_reg == AW'(SLOTS - 1))
        begin
            link_rd = LINK_NULL;
        end
        else
        begin
            link_rd = PW'(addr_q_reg) + PW'(1);
        end
    end

    assign data_rd = data_q_reg;

endmodule
`default_nettype wire

// ----- sv/multi_queue_shared_buffer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_top
// Several FIFO queues kept as linked lists in one shared slot store, with a
// free list of unused slots.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid, in_stall) carries command, queue_id and
//   value. An enqueue links a free slot behind the queue's tail; a dequeue
//   unlinks the head slot and returns its word. The result channel
//   (out_valid, out_stall) carries data_out, status, queue_empty and
//   store_full, one result per request, in request order.
//   In the transfer cycle of a request the link and word memories are read
//   at the free head or queue head; in the write-back state that follows,
//   the links and pointers are written back and the result is registered in
//   the output register. No new request is taken until that write-back is
//   done, set by the read-then-write of the link memory.
//   A request may be taken while the previous result still waits. If the
//   receiver stalls, the write-back cycle holds until the output register
//   is free, and in_stall stays high meanwhile.
//   Reset empties every queue and puts all slots on the free list at once;
//   there is no clearing pass, since untouched slots are tracked by a
//   high-water mark.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_top #(
    parameter int SLOTS      = 64,
    parameter int QUEUES     = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_stall,
    input  wire                                    command,
    input  wire  [mqsb_pkg::QID_WIDTH-1:0]         queue_id,
    input  wire  signed [mqsb_pkg::WORD_WIDTH-1:0] value,
    output logic                                   out_valid,
    input  wire                                    out_stall,
    output logic signed [mqsb_pkg::WORD_WIDTH-1:0] data_out,
    output logic [1:0]                             status,
    output logic                                   queue_empty,
    output logic                                   store_full
);

    localparam int WW  = mqsb_pkg::WORD_WIDTH;
    localparam int AW  = $clog2(SLOTS);
    localparam int PW  = $clog2(SLOTS + 1);
    localparam int QMAX = 1 << mqsb_pkg::QID_WIDTH;
    localparam int QN  = (QUEUES < QMAX) ? QUEUES : QMAX;
    localparam int QIW = (QN > 1) ? $clog2(QN) : 1;
    localparam logic [PW-1:0] LINK_NULL = PW'(SLOTS);

    mqsb_pkg::mqsb_state_t state_reg, state_next;

    logic                  cmd_reg;
    logic [mqsb_pkg::QID_WIDTH-1:0] qid_reg;
    logic [WW-1:0]         value_reg;

    logic [PW-1:0]         head_reg [QN];
    logic [PW-1:0]         tail_reg [QN];
    logic [PW-1:0]         free_head_reg;

    logic                  out_valid_reg;
    logic [WW-1:0]         data_out_reg;
    logic [1:0]            status_reg;
    logic                  queue_empty_reg;
    logic                  store_full_reg;

    logic                  accept;
    logic                  fire;
    logic                  out_free;
    logic                  in_qv;
    logic [QIW-1:0]        in_qidx;
    logic                  qv;
    logic [QIW-1:0]        qidx;
    logic [PW-1:0]         hq;
    logic [PW-1:0]         tq;
    logic                  enq_ok;
    logic                  deq_ok;
    logic [PW-1:0]         deq_next;
    logic [PW-1:0]         head_next;
    logic [PW-1:0]         tail_next;
    logic [PW-1:0]         free_head_next;
    logic [WW-1:0]         data_out_next;
    logic [1:0]            status_next;

    mqsb_pkg::mqsb_mem_ctl_t mem_ctl;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         link_wr_addr;
    logic [PW-1:0]         link_wr_data;
    logic [DATA_WIDTH-1:0] data_wr_data;
    logic [PW-1:0]         link_rd;
    logic [DATA_WIDTH-1:0] data_rd;
    logic [WW-1:0]         data_ext;

    // Word width conversion between the channel and the store.
    generate
        if (DATA_WIDTH >= WW)
        begin : g_wide
            assign data_ext     = data_rd[WW-1:0];
            assign data_wr_data = DATA_WIDTH'(value_reg);
        end
        else
        begin : g_narrow
            assign data_ext     = {{(WW - DATA_WIDTH){data_rd[DATA_WIDTH-1]}}, data_rd};
            assign data_wr_data = value_reg[DATA_WIDTH-1:0];
        end
    endgenerate

    // Request side: queue number check and read address.
    assign in_qv   = (32'(queue_id) < QUEUES);
    assign in_qidx = QIW'(queue_id);
    assign accept  = in_valid && !in_stall;

    always_comb
    begin
        if (command == mqsb_pkg::CMD_ENQ)
        begin
            rd_addr = free_head_reg[AW-1:0];
        end
        else if (in_qv)
        begin
            rd_addr = head_reg[in_qidx][AW-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // Latched request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            qid_reg   <= queue_id;
            value_reg <= value;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mqsb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mqsb_pkg::ST_EXEC;
                end
            end
            mqsb_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = mqsb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mqsb_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        in_stall = 1'b1;
        fire     = 1'b0;
        unique case (state_reg)
            mqsb_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            mqsb_pkg::ST_EXEC:
            begin
                fire = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mqsb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Write-back decision for the latched request.
    assign qv     = (32'(qid_reg) < QUEUES);
    assign qidx   = QIW'(qid_reg);
    assign hq     = qv ? head_reg[qidx] : LINK_NULL;
    assign tq     = qv ? tail_reg[qidx] : LINK_NULL;
    assign enq_ok = (cmd_reg == mqsb_pkg::CMD_ENQ) && qv && (free_head_reg != LINK_NULL);
    assign deq_ok = (cmd_reg == mqsb_pkg::CMD_DEQ) && (hq != LINK_NULL);

    // The tail's stored link is never kept up to date, so the tail ends the list.
    assign deq_next = (hq == tq) ? LINK_NULL : link_rd;

    always_comb
    begin
        head_next      = hq;
        tail_next      = tq;
        free_head_next = free_head_reg;
        mem_ctl        = '0;
        mem_ctl.rd_en  = accept;
        link_wr_addr   = tq[AW-1:0];
        link_wr_data   = free_head_reg;
        data_out_next  = '0;
        status_next    = mqsb_pkg::STATUS_DONE;
        priority if (enq_ok)
        begin
            free_head_next   = link_rd;
            tail_next        = free_head_reg;
            mem_ctl.data_we  = fire;
            if (hq == LINK_NULL)
            begin
                head_next = free_head_reg;
            end
            else
            begin
                mem_ctl.link_we = fire;
                link_wr_addr    = tq[AW-1:0];
                link_wr_data    = free_head_reg;
            end
        end
        else if (deq_ok)
        begin
            head_next       = deq_next;
            free_head_next  = hq;
            mem_ctl.link_we = fire;
            link_wr_addr    = hq[AW-1:0];
            link_wr_data    = free_head_reg;
            data_out_next   = data_ext;
            if (deq_next == LINK_NULL)
            begin
                tail_next = LINK_NULL;
            end
        end
        else if (cmd_reg == mqsb_pkg::CMD_DEQ)
        begin
            data_out_next = '1;
            status_next   = mqsb_pkg::STATUS_EMPTY;
        end
        else
        begin
            status_next = mqsb_pkg::STATUS_FULL;
        end
    end

    // Queue and free list pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QN; i++)
            begin
                head_reg[i] <= LINK_NULL;
                tail_reg[i] <= LINK_NULL;
            end
            free_head_reg <= '0;
        end
        else if (fire)
        begin
            if (enq_ok || deq_ok)
            begin
                head_reg[qidx] <= head_next;
                tail_reg[qidx] <= tail_next;
            end
            free_head_reg <= free_head_next;
        end
    end

    // Output register: filled by the write-back cycle, emptied by a transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_out_reg    <= data_out_next;
            status_reg      <= status_next;
            queue_empty_reg <= !qv || (head_next == LINK_NULL);
            store_full_reg  <= (free_head_next == LINK_NULL);
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_out    = data_out_reg;
    assign status      = status_reg;
    assign queue_empty = queue_empty_reg;
    assign store_full  = store_full_reg;

    // Slot store.
    mqsb_slot_store #(
        .SLOTS      (SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (mem_ctl),
        .rd_addr      (rd_addr),
        .link_wr_addr (link_wr_addr),
        .link_wr_data (link_wr_data),
        .data_wr_addr (free_head_reg[AW-1:0]),
        .data_wr_data (data_wr_data),
        .link_rd      (link_rd),
        .data_rd      (data_rd)
    );

    // A taken request is always followed by a write-back cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == mqsb_pkg::ST_EXEC))
        else $error("write-back cycle missing after request transfer");

    // A new result only appears after a write-back cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == mqsb_pkg::ST_EXEC))
        else $error("result appeared without a write-back cycle");

    // A queue's head and tail are null together.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mqsb_pkg::ST_EXEC) |-> ((hq == LINK_NULL) == (tq == LINK_NULL)))
        else $error("queue head and tail disagree on emptiness");

    // The free head is a slot or null, never beyond.
    assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= LINK_NULL)
        else $error("free head out of range");

    // A successful enqueue reports done with a zero word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && enq_ok) |=> (status == mqsb_pkg::STATUS_DONE) && (data_out == '0))
        else $error("enqueue result malformed");

endmodule
`default_nettype wire
